/* sv/ifdyu_pkg.sv */
package ifdyu_pkg;

	localparam int unsigned NUM_LANES   = 4;
	localparam int unsigned LIMIT_W     = 31;
	localparam int unsigned RAW_W       = 16;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned ACC_W       = 48;
	localparam int unsigned TICK_W      = 12;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned BUS_ID_W    = 8;
	localparam int unsigned REQ_W       = 3;

	localparam int unsigned TICK_WRAP_DEF = 4000;

	// register map
	localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_LIMIT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_LIMIT  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_LIMIT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_YAW_LIMIT   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROLL_LIMIT  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_QUAT_LIMIT  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_REQUEST_ID  = 3'd6;

	localparam logic [LIMIT_W-1:0]  ACCEL_LIMIT_RST = 31'd15414067;
	localparam logic [LIMIT_W-1:0]  GYRO_LIMIT_RST  = 31'd2285895;
	localparam logic [LIMIT_W-1:0]  PITCH_LIMIT_RST = 31'd5898240;
	localparam logic [LIMIT_W-1:0]  YAW_LIMIT_RST   = 31'd11796480;
	localparam logic [LIMIT_W-1:0]  ROLL_LIMIT_RST  = 31'd11796480;
	localparam logic [LIMIT_W-1:0]  QUAT_LIMIT_RST  = 31'd65536;
	localparam logic [BUS_ID_W-1:0] REQUEST_ID_RST  = 8'd0;

	// frame type byte
	localparam logic [7:0] FT_ACCEL = 8'd1;
	localparam logic [7:0] FT_GYRO  = 8'd2;
	localparam logic [7:0] FT_EULER = 8'd3;
	localparam logic [7:0] FT_QUAT  = 8'd4;

	// half a turn and a full turn in Q16.16 degrees
	localparam logic signed [33:0] DEG180 = 34'sd11796480;
	localparam logic signed [33:0] DEG360 = 34'sd23592960;

	typedef enum logic [2:0] {
		KIND_ACCEL   = 3'd0,
		KIND_GYRO    = 3'd1,
		KIND_EULER   = 3'd2,
		KIND_QUAT    = 3'd3,
		KIND_TICK    = 3'd4,
		KIND_IGNORED = 3'd5
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

endpackage

/* sv/ifdyu_scale_lane.sv */
// One scaling lane: value = round(raw * 2 * limit / (2^n - 1)) - limit,
// n = 16, or 14 when narrow is set. Three stages, all moving on adv.
module ifdyu_scale_lane
	import ifdyu_pkg::*;
(
	input  logic                      clk,
	input  logic                      adv,
	input  logic [RAW_W-1:0]          raw,
	input  logic [LIMIT_W-1:0]        limit,
	input  logic                      narrow,
	output logic signed [VALUE_W-1:0] value
);

	localparam int unsigned PROD_W = RAW_W + LIMIT_W;
	localparam int unsigned X_W    = PROD_W + 1;
	localparam int unsigned Q_W    = 34;
	localparam int unsigned R_W    = 18;

	localparam logic [X_W-1:0] HALF16 = 48'd32767;
	localparam logic [X_W-1:0] HALF14 = 48'd8191;
	localparam logic [R_W-1:0] DEN16  = 18'd65535;
	localparam logic [R_W-1:0] DEN14  = 18'd16383;

	logic [PROD_W-1:0]  prod_s1;
	logic [LIMIT_W-1:0] limit_s1, limit_s2;
	logic               narrow_s1, narrow_s2;

	logic [X_W-1:0]     x;
	logic [Q_W-1:0]     qa;
	logic [R_W-1:0]     x_lo_s2;
	logic [Q_W-1:0]     qa_s2;

	logic [R_W-1:0]     r_full, r, den;
	logic [1:0]         corr;
	logic [Q_W-1:0]     q;

	// stage 1: the one multiplier of the lane
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= PROD_W'(raw) * PROD_W'(limit);
			limit_s1  <= limit;
			narrow_s1 <= narrow;
		end
	end

	// stage 2: quotient estimate by the series x/2^n + x/2^2n + x/2^3n,
	// at most three short of the true floor
	always_comb begin
		x = {prod_s1, 1'b0} + (narrow_s1 ? HALF14 : HALF16);
		if (narrow_s1) begin
			qa = Q_W'(x >> 14) + Q_W'(x >> 28) + Q_W'(x >> 42);
		end else begin
			qa = Q_W'(x >> 16) + Q_W'(x >> 32);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_lo_s2   <= x[R_W-1:0];
			qa_s2     <= qa;
			limit_s2  <= limit_s1;
			narrow_s2 <= narrow_s1;
		end
	end

	// stage 3: remainder lies below four divisors, so it is exact modulo 2^(n+2)
	always_comb begin
		if (narrow_s2) begin
			r_full = x_lo_s2 - {qa_s2[3:0], 14'd0} + qa_s2[R_W-1:0];
			r      = {2'b00, r_full[15:0]};
			den    = DEN14;
		end else begin
			r_full = x_lo_s2 - {qa_s2[1:0], 16'd0} + qa_s2[R_W-1:0];
			r      = r_full;
			den    = DEN16;
		end
		corr = 2'(r >= den) + 2'(r >= R_W'(den * 2)) + 2'(r >= R_W'(den * 3));
		q    = qa_s2 + Q_W'(corr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value <= VALUE_W'(q - Q_W'(limit_s2));
		end
	end

endmodule

/* sv/ifdyu_merge.sv */
// Merge stage: gathers the lane results, applies the state updates in item
// order and holds the output word.
module ifdyu_merge
	import ifdyu_pkg::*;
#(
	parameter int unsigned TICK_WRAP = TICK_WRAP_DEF
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  ctl_t                      ctl_s3,
	input  logic signed [VALUE_W-1:0] val_a,
	input  logic signed [VALUE_W-1:0] val_b,
	input  logic signed [VALUE_W-1:0] val_c,
	input  logic signed [VALUE_W-1:0] val_d,
	input  logic [BUS_ID_W-1:0]       request_id,
	output logic                      out_valid,
	output kind_t                     out_kind,
	output logic signed [VALUE_W-1:0] value_a,
	output logic signed [VALUE_W-1:0] value_b,
	output logic signed [VALUE_W-1:0] value_c,
	output logic signed [VALUE_W-1:0] value_d,
	output logic [REQ_W-1:0]          request_reg,
	output logic [BUS_ID_W-1:0]       request_bus_id,
	output logic signed [ACC_W-1:0]   yaw_total
);

	logic [TICK_W-1:0]         tick_count_q, cnt_inc, cnt_next;
	logic signed [VALUE_W-1:0] cur_yaw_q, prev_yaw_q;
	logic signed [ACC_W-1:0]   yaw_acc_q, acc_next;
	logic signed [33:0]        delta, delta_w;
	logic                      take, is_tick, is_euler, is_decode, is_quat;

	always_comb begin
		take      = adv && ctl_s3.valid;
		is_tick   = ctl_s3.kind == KIND_TICK;
		is_euler  = ctl_s3.kind == KIND_EULER;
		is_quat   = ctl_s3.kind == KIND_QUAT;
		is_decode = ctl_s3.kind inside {KIND_ACCEL, KIND_GYRO, KIND_EULER, KIND_QUAT};

		cnt_inc  = tick_count_q + 1'b1;
		cnt_next = (cnt_inc >= TICK_W'(TICK_WRAP)) ? '0 : cnt_inc;

		delta = 34'(cur_yaw_q) - 34'(prev_yaw_q);
		if (delta < -DEG180) begin
			delta_w = delta + DEG360;
		end else if (delta > DEG180) begin
			delta_w = delta - DEG360;
		end else begin
			delta_w = delta;
		end
		acc_next = yaw_acc_q + ACC_W'(delta_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			tick_count_q <= '0;
			cur_yaw_q    <= '0;
			prev_yaw_q   <= '0;
			yaw_acc_q    <= '0;
		end else begin
			if (adv) begin
				out_valid <= ctl_s3.valid;
			end
			if (take && is_tick) begin
				tick_count_q <= cnt_next;
				prev_yaw_q   <= cur_yaw_q;
				yaw_acc_q    <= acc_next;
			end
			if (take && is_euler) begin
				cur_yaw_q <= val_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_kind       <= ctl_s3.kind;
			value_a        <= is_decode ? val_a : '0;
			value_b        <= is_decode ? val_b : '0;
			value_c        <= is_decode ? val_c : '0;
			value_d        <= is_quat ? val_d : '0;
			request_reg    <= is_tick ? {1'b0, cnt_inc[1:0]} + 1'b1 : '0;
			request_bus_id <= is_tick ? request_id : '0;
			yaw_total      <= (ctl_s3.valid && is_tick) ? acc_next : yaw_acc_q;
		end
	end

	a_tick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q < TICK_W'(TICK_WRAP))
		else $error("tick counter past its wrap value");

	a_acc_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && is_tick) |=> $stable(yaw_acc_q))
		else $error("yaw total moved without a tick");

	a_req_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_kind == KIND_TICK) == (request_reg != '0)))
		else $error("request register out of step with word kind");

	a_value_d_quat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_QUAT) |-> (value_d == '0))
		else $error("fourth component set on a non-quaternion word");

endmodule

/* sv/imu_frame_decode_yaw_unwrap.sv */
// IMU frame decoder with yaw unwrapping.
// Slave stream: s_tuser carries the action flag and the frame type byte,
// s_tdata the seven payload bytes. A word is either a sensor frame (type 1
// accel, 2 gyro, 3 pitch/yaw/roll, 4 quaternion, anything else ignored) or
// a polling tick. Master stream: one result word per input word, in order.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the six full-scale limits
// and the request bus id; write only while no word is in flight.
// Pipeline: four register stages (multiply, quotient estimate, remainder
// correction, merge/output register) that every word passes in order.
// Throughput: one word per cycle while no stall holds the pipeline; four
// scaling lanes run side by side, each with one 16x31 multiplier, and the
// merge stage applies tick and yaw state in word order, so a tick directly
// after a yaw frame sees the new yaw.
// Reset: limits return to their defaults, tick counter, yaw and running
// total clear, and both streams are empty.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready drops; nothing is lost.
module imu_frame_decode_yaw_unwrap
	import ifdyu_pkg::*;
#(
	parameter int unsigned TICK_WRAP = TICK_WRAP_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [55:0]           s_tdata,   // byte1..byte7, byte1 lowest
	input  logic [8:0]            s_tuser,   // action [0], byte0 [8:1]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// value_a [31:0], value_b [63:32], value_c [95:64], value_d [127:96],
	// request_reg [130:128], request_bus_id [138:131], yaw_total [186:139]
	output logic [191:0]          m_tdata,
	output logic [2:0]            m_tuser,   // kind [2:0]
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [LIMIT_W-1:0]    cfg_wdata
);

	logic [LIMIT_W-1:0]  accel_limit_q, gyro_limit_q, pitch_limit_q;
	logic [LIMIT_W-1:0]  yaw_limit_q, roll_limit_q, quat_limit_q;
	logic [BUS_ID_W-1:0] request_id_q;

	logic                adv;
	logic                action;
	logic [7:0]          ftype;
	logic [7:0]          b1, b2, b3, b4, b5, b6, b7;
	logic [RAW_W-1:0]    raw_sel [NUM_LANES];
	logic [LIMIT_W-1:0]  lim_sel [NUM_LANES];
	logic                narrow;
	kind_t               kind_in;

	ctl_t                ctl_s1, ctl_s2, ctl_s3;
	logic signed [VALUE_W-1:0] lane_val [NUM_LANES];

	kind_t                     out_kind;
	logic signed [VALUE_W-1:0] value_a, value_b, value_c, value_d;
	logic [REQ_W-1:0]          request_reg;
	logic [BUS_ID_W-1:0]       request_bus_id;
	logic signed [ACC_W-1:0]   yaw_total;

	// register writes; no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_limit_q <= ACCEL_LIMIT_RST;
			gyro_limit_q  <= GYRO_LIMIT_RST;
			pitch_limit_q <= PITCH_LIMIT_RST;
			yaw_limit_q   <= YAW_LIMIT_RST;
			roll_limit_q  <= ROLL_LIMIT_RST;
			quat_limit_q  <= QUAT_LIMIT_RST;
			request_id_q  <= REQUEST_ID_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ACCEL_LIMIT: accel_limit_q <= cfg_wdata;
				CFG_GYRO_LIMIT:  gyro_limit_q  <= cfg_wdata;
				CFG_PITCH_LIMIT: pitch_limit_q <= cfg_wdata;
				CFG_YAW_LIMIT:   yaw_limit_q   <= cfg_wdata;
				CFG_ROLL_LIMIT:  roll_limit_q  <= cfg_wdata;
				CFG_QUAT_LIMIT:  quat_limit_q  <= cfg_wdata;
				CFG_REQUEST_ID:  request_id_q  <= cfg_wdata[BUS_ID_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline whenever the output register is free or
	// being emptied this cycle
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// unpack the frame and steer raw values and limits onto the lanes
	always_comb begin
		action = s_tuser[0];
		ftype  = s_tuser[8:1];
		b1 = s_tdata[7:0];
		b2 = s_tdata[15:8];
		b3 = s_tdata[23:16];
		b4 = s_tdata[31:24];
		b5 = s_tdata[39:32];
		b6 = s_tdata[47:40];
		b7 = s_tdata[55:48];

		raw_sel[0] = {b3, b2};
		raw_sel[1] = {b5, b4};
		raw_sel[2] = {b7, b6};
		raw_sel[3] = '0;
		narrow     = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			lim_sel[i] = '0;
		end

		if (action) begin
			kind_in = KIND_TICK;
		end else begin
			case (ftype)
				FT_ACCEL: begin
					kind_in = KIND_ACCEL;
					lim_sel[0] = accel_limit_q;
					lim_sel[1] = accel_limit_q;
					lim_sel[2] = accel_limit_q;
				end
				FT_GYRO: begin
					kind_in = KIND_GYRO;
					lim_sel[0] = gyro_limit_q;
					lim_sel[1] = gyro_limit_q;
					lim_sel[2] = gyro_limit_q;
				end
				FT_EULER: begin
					kind_in = KIND_EULER;
					lim_sel[0] = pitch_limit_q;
					lim_sel[1] = yaw_limit_q;
					lim_sel[2] = roll_limit_q;
				end
				FT_QUAT: begin
					// four packed 14-bit components w, x, y, z
					kind_in = KIND_QUAT;
					narrow  = 1'b1;
					raw_sel[0] = {2'b00, b1, b2[7:2]};
					raw_sel[1] = {2'b00, b2[1:0], b3, b4[7:4]};
					raw_sel[2] = {2'b00, b4[3:0], b5, b6[7:6]};
					raw_sel[3] = {2'b00, b6[5:0], b7};
					for (int i = 0; i < NUM_LANES; i++) begin
						lim_sel[i] = quat_limit_q;
					end
				end
				default: kind_in = KIND_IGNORED;
			endcase
		end
	end

	// control travels alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: s_tvalid, kind: kind_in};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ifdyu_scale_lane u_lane (
			.clk    (clk),
			.adv    (adv),
			.raw    (raw_sel[g]),
			.limit  (lim_sel[g]),
			.narrow (narrow),
			.value  (lane_val[g])
		);
	end

	ifdyu_merge #(
		.TICK_WRAP (TICK_WRAP)
	) u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.ctl_s3         (ctl_s3),
		.val_a          (lane_val[0]),
		.val_b          (lane_val[1]),
		.val_c          (lane_val[2]),
		.val_d          (lane_val[3]),
		.request_id     (request_id_q),
		.out_valid      (m_tvalid),
		.out_kind       (out_kind),
		.value_a        (value_a),
		.value_b        (value_b),
		.value_c        (value_c),
		.value_d        (value_d),
		.request_reg    (request_reg),
		.request_bus_id (request_bus_id),
		.yaw_total      (yaw_total)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {5'd0, yaw_total, request_bus_id, request_reg,
	                  value_d, value_c, value_b, value_a};

endmodule

/* bench/imu_frame_decode_yaw_unwrap_tb.sv */
`timescale 1ns / 1ps

module imu_frame_decode_yaw_unwrap_tb;
	import ifdyu_pkg::*;

	// cycle budget: the slowest correct run stays well under this limit
	localparam int unsigned CYCLE_LIMIT   = 150000;
	localparam int unsigned REPORT_CAP    = 40;
	localparam int unsigned TAIL_CYCLES   = 8;
	localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;
	localparam logic [LIMIT_W-1:0]    LIMIT_MAX    = 31'h7FFF_FFFF;
	localparam logic [LIMIT_W-1:0]    NINETY_DEG   = 31'd5898240;

	// one input word as the sender sees it; payload byte k sits at [8k-1:8k-8]
	typedef struct packed {
		logic        action;
		logic [7:0]  ftype;
		logic [55:0] payload;
	} imu_word_t;

	// one decoded word as it leaves the block
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic signed [31:0] value_d;
		logic [2:0]         req_reg;
		logic [7:0]         bus_id;
		logic [47:0]        heading;
	} decoded_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [55:0]           s_tdata   = '0;   // byte1..byte7, byte1 lowest
	logic [8:0]            s_tuser   = '0;   // action [0], byte0 [8:1]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// value_a, value_b, value_c, value_d, request_reg, request_bus_id, yaw_total
	logic [191:0]          m_tdata;
	logic [2:0]            m_tuser;          // kind [2:0]
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [LIMIT_W-1:0]    cfg_wdata = '0;

	imu_frame_decode_yaw_unwrap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// words still to send, and decoded words still owed by the block
	imu_word_t pending_words[$];
	decoded_t  awaited_decodes[$];

	// percentage of cycles in which the sender holds back / the receiver stalls
	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned faults = 0;
	int unsigned cycles = 0;
	bit          word_taken = 1'b0;

	// shadow of the block's registers and state
	logic [LIMIT_W-1:0]  full_scale [0:5];
	logic [BUS_ID_W-1:0] bus_id;
	logic [TICK_W-1:0]   tick_count;
	logic signed [31:0]  yaw_now;
	logic signed [31:0]  yaw_at_tick;
	logic [ACC_W-1:0]    heading_sum;

	initial begin
		full_scale[CFG_ACCEL_LIMIT] = ACCEL_LIMIT_RST;
		full_scale[CFG_GYRO_LIMIT]  = GYRO_LIMIT_RST;
		full_scale[CFG_PITCH_LIMIT] = PITCH_LIMIT_RST;
		full_scale[CFG_YAW_LIMIT]   = YAW_LIMIT_RST;
		full_scale[CFG_ROLL_LIMIT]  = ROLL_LIMIT_RST;
		full_scale[CFG_QUAT_LIMIT]  = QUAT_LIMIT_RST;
		bus_id      = REQUEST_ID_RST;
		tick_count  = '0;
		yaw_now     = '0;
		yaw_at_tick = '0;
		heading_sum = '0;
	end

	// map an n-bit raw reading onto -lim..+lim, quotient rounded half up
	function automatic logic signed [31:0] scale_q16(input logic [15:0] raw,
			input logic [LIMIT_W-1:0] lim, input int unsigned nbits);
		longint unsigned den;
		longint unsigned num;
		longint unsigned quo;
		den = (64'd1 << nbits) - 64'd1;
		num = 64'(raw) * 64'd2 * 64'(lim);
		quo = (num + den / 64'd2) / den;
		return 32'(longint'(quo) - longint'(lim));
	endfunction

	// decode one accepted word and advance the shadow state
	function automatic decoded_t decode_word(input imu_word_t w);
		decoded_t   d;
		logic [7:0] b [1:7];
		longint     step;
		logic [15:0] qw, qx, qy, qz;
		for (int k = 1; k <= 7; k++)
			b[k] = w.payload[8*(k-1) +: 8];
		d = '0;
		d.kind = KIND_IGNORED;
		if (w.action) begin
			// count first, pick the register, then wrap the counter
			tick_count = tick_count + 1'b1;
			d.req_reg  = {1'b0, tick_count[1:0]} + 3'd1;
			if (tick_count >= TICK_WRAP_DEF)
				tick_count = '0;
			// fold the yaw change into +-180 degrees; exactly 180 stays as is
			step = longint'(yaw_now) - longint'(yaw_at_tick);
			if (step < -longint'(DEG180))
				step += longint'(DEG360);
			else if (step > longint'(DEG180))
				step -= longint'(DEG360);
			heading_sum = heading_sum + 48'(step);
			yaw_at_tick = yaw_now;
			d.kind   = KIND_TICK;
			d.bus_id = bus_id;
		end else begin
			case (w.ftype)
				FT_ACCEL: begin
					d.kind    = KIND_ACCEL;
					d.value_a = scale_q16({b[3], b[2]}, full_scale[CFG_ACCEL_LIMIT], RAW_W);
					d.value_b = scale_q16({b[5], b[4]}, full_scale[CFG_ACCEL_LIMIT], RAW_W);
					d.value_c = scale_q16({b[7], b[6]}, full_scale[CFG_ACCEL_LIMIT], RAW_W);
				end
				FT_GYRO: begin
					d.kind    = KIND_GYRO;
					d.value_a = scale_q16({b[3], b[2]}, full_scale[CFG_GYRO_LIMIT], RAW_W);
					d.value_b = scale_q16({b[5], b[4]}, full_scale[CFG_GYRO_LIMIT], RAW_W);
					d.value_c = scale_q16({b[7], b[6]}, full_scale[CFG_GYRO_LIMIT], RAW_W);
				end
				FT_EULER: begin
					d.kind    = KIND_EULER;
					d.value_a = scale_q16({b[3], b[2]}, full_scale[CFG_PITCH_LIMIT], RAW_W);
					yaw_now   = scale_q16({b[5], b[4]}, full_scale[CFG_YAW_LIMIT], RAW_W);
					d.value_b = yaw_now;
					d.value_c = scale_q16({b[7], b[6]}, full_scale[CFG_ROLL_LIMIT], RAW_W);
				end
				FT_QUAT: begin
					// four 14-bit components packed back to back from byte1
					qw = {2'b00, b[1], b[2][7:2]};
					qx = {2'b00, b[2][1:0], b[3], b[4][7:4]};
					qy = {2'b00, b[4][3:0], b[5], b[6][7:6]};
					qz = {2'b00, b[6][5:0], b[7]};
					d.kind    = KIND_QUAT;
					d.value_a = scale_q16(qw, full_scale[CFG_QUAT_LIMIT], 14);
					d.value_b = scale_q16(qx, full_scale[CFG_QUAT_LIMIT], 14);
					d.value_c = scale_q16(qy, full_scale[CFG_QUAT_LIMIT], 14);
					d.value_d = scale_q16(qz, full_scale[CFG_QUAT_LIMIT], 14);
				end
				default: ;
			endcase
		end
		d.heading = heading_sum;
		return d;
	endfunction

	function automatic imu_word_t frame(input logic [7:0] ftype, input logic [55:0] payload);
		return {1'b0, ftype, payload};
	endfunction

	// payload and type bits of a tick are noise the block must disregard
	function automatic imu_word_t tick_word();
		return {1'b1, 8'($urandom), 56'({$urandom, $urandom})};
	endfunction

	function automatic imu_word_t random_word();
		logic [7:0]  ftype;
		logic [55:0] payload;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			return tick_word();
		// mostly known frame types, the rest any byte at all
		if ($urandom_range(99) < 88)
			ftype = 8'($urandom_range(FT_ACCEL, FT_QUAT));
		else
			ftype = 8'($urandom);
		payload = 56'({$urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 6)
			payload = '0;
		else if (pick < 12)
			payload = '1;
		return frame(ftype, payload);
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			faults++;
			if (faults <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// register write on the next falling edge; the shadow follows at once
	// since the block is idle whenever this is called
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [LIMIT_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		case (addr)
			CFG_ACCEL_LIMIT, CFG_GYRO_LIMIT, CFG_PITCH_LIMIT,
			CFG_YAW_LIMIT, CFG_ROLL_LIMIT, CFG_QUAT_LIMIT:
				full_scale[addr] = data;
			CFG_REQUEST_ID:
				bus_id = data[BUS_ID_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every word is sent and every decode has come back
	task automatic wait_drained();
		while (pending_words.size() != 0 || s_tvalid || awaited_decodes.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(input int unsigned n);
		repeat (n)
			pending_words.push_back(random_word());
	endtask

	// sender: present a new word once the last one is gone, gaps at random
	always @(negedge clk) begin : drive_words
		imu_word_t next_word;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!s_tvalid || word_taken) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= {next_word.ftype, next_word.action};
					s_tdata  <= next_word.payload;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check what leaves, then predict for what was accepted
	always @(posedge clk) begin : watch_streams
		decoded_t want;
		decoded_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind    = kind_t'(m_tuser);
				got.value_a = m_tdata[31:0];
				got.value_b = m_tdata[63:32];
				got.value_c = m_tdata[95:64];
				got.value_d = m_tdata[127:96];
				got.req_reg = m_tdata[130:128];
				got.bus_id  = m_tdata[138:131];
				got.heading = m_tdata[186:139];
				if (awaited_decodes.size() == 0) begin
					faults++;
					if (faults <= REPORT_CAP)
						$display("%0t: unexpected word, expected none, got %0h", $time, got);
				end else begin
					want = awaited_decodes.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("value_a", want.value_a, got.value_a);
					check_field("value_b", want.value_b, got.value_b);
					check_field("value_c", want.value_c, got.value_c);
					check_field("value_d", want.value_d, got.value_d);
					check_field("request_reg", want.req_reg, got.req_reg);
					check_field("request_bus_id", want.bus_id, got.bus_id);
					check_field("yaw_total", want.heading, got.heading);
				end
			end
			word_taken = s_tvalid && s_tready;
			if (word_taken)
				awaited_decodes.push_back(decode_word({s_tuser[0], s_tuser[8:1], s_tdata}));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words against the reset limits; sender gaps light, receiver stalls heavy
		send_gap_pct   = 17;
		recv_stall_pct = 57;
		pending_words.push_back(frame(FT_ACCEL, 56'h00_00_00_00_00_00_00));
		pending_words.push_back(frame(FT_ACCEL, 56'hFF_FF_FF_FF_FF_FF_FF));
		pending_words.push_back(frame(FT_GYRO,  56'h00_01_7F_FF_80_00_C3));
		// yaw to +180, tick keeps a change of exactly +180
		pending_words.push_back(frame(FT_EULER, 56'hFF_FF_FF_FF_00_00_00));
		pending_words.push_back(tick_word());
		// yaw to -180, tick sees -360 and folds it up
		pending_words.push_back(frame(FT_EULER, 56'h00_00_00_00_FF_FF_5A));
		pending_words.push_back(tick_word());
		// back to +180, tick sees +360 and folds it down
		pending_words.push_back(frame(FT_EULER, 56'hFF_FF_FF_FF_00_00_00));
		pending_words.push_back(tick_word());
		pending_words.push_back(frame(FT_QUAT,  56'hFF_FF_FF_FF_FF_FF_FF));
		pending_words.push_back(frame(FT_QUAT,  56'h00_00_00_00_00_00_00));
		// quaternion byte boundaries, as two complementary bit patterns
		pending_words.push_back(frame(FT_QUAT,  56'h00_C0_00_0F_00_FC_00));
		pending_words.push_back(frame(FT_QUAT,  56'hFF_3F_FF_F0_FF_03_FF));
		// unknown frame types leave everything alone
		pending_words.push_back(frame(8'h00,    56'h12_34_56_78_9A_BC_DE));
		pending_words.push_back(frame(8'hFF,    56'hFF_FF_FF_FF_FF_FF_FF));
		pending_words.push_back(frame(8'h05,    56'hA5_5A_A5_5A_A5_5A_A5));
		// a run of ticks walks the request register through all four values
		repeat (5)
			pending_words.push_back(tick_word());
		wait_drained();

		// extreme limits, yaw at +-90 so a swing across is exactly -180
		write_reg(CFG_ACCEL_LIMIT, '0);
		write_reg(CFG_GYRO_LIMIT,  LIMIT_MAX);
		write_reg(CFG_PITCH_LIMIT, LIMIT_MAX);
		write_reg(CFG_YAW_LIMIT,   NINETY_DEG);
		write_reg(CFG_ROLL_LIMIT,  31'd1);
		write_reg(CFG_QUAT_LIMIT,  LIMIT_MAX);
		write_reg(CFG_REQUEST_ID,  31'h5555_55A5);
		write_reg(CFG_UNMAPPED,    31'($urandom));
		pending_words.push_back(frame(FT_EULER, 56'h00_00_FF_FF_00_00_00));
		pending_words.push_back(tick_word());
		pending_words.push_back(frame(FT_EULER, 56'hFF_FF_00_00_FF_FF_00));
		pending_words.push_back(tick_word());
		queue_random(150);
		wait_drained();

		// any limits at all; now the sender is the slow side
		send_gap_pct   = 57;
		recv_stall_pct = 17;
		write_reg(CFG_ACCEL_LIMIT, 31'($urandom));
		write_reg(CFG_GYRO_LIMIT,  31'($urandom));
		write_reg(CFG_PITCH_LIMIT, 31'($urandom));
		write_reg(CFG_YAW_LIMIT,   31'($urandom));
		write_reg(CFG_ROLL_LIMIT,  31'($urandom));
		write_reg(CFG_QUAT_LIMIT,  31'($urandom));
		write_reg(CFG_REQUEST_ID,  31'($urandom_range(255)));
		queue_random(150);
		wait_drained();

		// modest limits at full rate
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		write_reg(CFG_ACCEL_LIMIT, 31'($urandom_range(1, 1 << 22)));
		write_reg(CFG_GYRO_LIMIT,  31'($urandom_range(1, 1 << 22)));
		write_reg(CFG_PITCH_LIMIT, PITCH_LIMIT_RST);
		write_reg(CFG_YAW_LIMIT,   YAW_LIMIT_RST);
		write_reg(CFG_ROLL_LIMIT,  ROLL_LIMIT_RST);
		write_reg(CFG_QUAT_LIMIT,  31'($urandom_range(1, 1 << 18)));
		write_reg(CFG_REQUEST_ID,  31'hFF);
		queue_random(125);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0 && awaited_decodes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
